// ----- rtl/qtps_pkg.sv -----
// ----------------------------------------------------------------------------
// qtps_pkg
// Shared constants, types and the note pattern ROM of the tone sequencer.
// ----------------------------------------------------------------------------
package qtps_pkg;

  localparam int QUEUE_DEPTH  = 8;
  localparam int MODULE_COUNT = 8;
  localparam int QIDX_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int CUE_W      = 5;
  localparam int CUE_COUNT  = 32;
  localparam int MASK_W     = 16;
  localparam int TIME_W     = 32;
  localparam int NOTE_W     = 16;
  localparam int MAX_NOTES  = 4;
  localparam int POS_W      = $clog2(MAX_NOTES + 1);
  localparam int NIDX_W     = $clog2(MAX_NOTES);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [MASK_W-1:0] SPEAKER_BIT = 16'h8000;
  localparam logic [MASK_W-1:0] MODULE_BITS = MASK_W'((1 << MODULE_COUNT) - 1);

  typedef enum logic [1:0] {
    KIND_REQUEST = 2'd0,
    KIND_TICK    = 2'd1,
    KIND_CLEAR   = 2'd2,
    KIND_NOP     = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AUDIO_ENABLED   = 2'd0,
    CFG_MUTED_MASK      = 2'd1,
    CFG_SPEAKER_AUDIBLE = 2'd2,
    CFG_UNUSED          = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic              audio_enabled;
    logic [MASK_W-1:0] muted_mask;
    logic              speaker_audible;
  } cfg_t;

  typedef struct packed {
    logic [MASK_W-1:0] mask;
    logic [CUE_W-1:0]  cue;
  } job_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic flush;
    job_t push_job;
  } q_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
    job_t head_job;
  } q_status_t;

  typedef struct packed {
    logic              valid;
    logic [MASK_W-1:0] mask;
    logic [NOTE_W-1:0] hz;
    logic [NOTE_W-1:0] dur;
  } tone_t;

  typedef struct packed {
    logic [NOTE_W-1:0] hz;
    logic [NOTE_W-1:0] dur;
    logic [NOTE_W-1:0] gap;
  } note_t;

  localparam note_t NN = '{16'd0, 16'd0, 16'd0};

  localparam logic [POS_W-1:0] NOTE_TOTAL [CUE_COUNT] = '{
    3'd2, 3'd3, 3'd3, 3'd2, 3'd2, 3'd4, 3'd1, 3'd2,
    3'd1, 3'd1, 3'd1, 3'd1, 3'd0, 3'd2, 3'd2, 3'd1,
    3'd2, 3'd2, 3'd3, 3'd3, 3'd2, 3'd3, 3'd2, 3'd2,
    3'd2, 3'd3, 3'd3, 3'd2, 3'd3, 3'd2, 3'd2, 3'd2
  };

  localparam note_t TONE_ROM [CUE_COUNT][MAX_NOTES] = '{
    '{'{16'd800, 16'd60, 16'd35}, '{16'd1100, 16'd90, 16'd0}, NN, NN},
    '{'{16'd700, 16'd65, 16'd35}, '{16'd1050, 16'd65, 16'd35},
      '{16'd1450, 16'd120, 16'd0}, NN},
    '{'{16'd1450, 16'd65, 16'd35}, '{16'd1000, 16'd65, 16'd35},
      '{16'd650, 16'd120, 16'd0}, NN},
    '{'{16'd950, 16'd65, 16'd40}, '{16'd1250, 16'd95, 16'd0}, NN, NN},
    '{'{16'd1100, 16'd70, 16'd35}, '{16'd1500, 16'd110, 16'd0}, NN, NN},
    '{'{16'd750, 16'd55, 16'd35}, '{16'd950, 16'd55, 16'd35},
      '{16'd1200, 16'd55, 16'd35}, '{16'd1550, 16'd120, 16'd0}},
    '{'{16'd650, 16'd120, 16'd0}, NN, NN, NN},
    '{'{16'd650, 16'd80, 16'd35}, '{16'd400, 16'd130, 16'd0}, NN, NN},
    '{'{16'd1000, 16'd120, 16'd0}, NN, NN, NN},
    '{'{16'd1300, 16'd120, 16'd0}, NN, NN, NN},
    '{'{16'd1700, 16'd120, 16'd0}, NN, NN, NN},
    '{'{16'd1000, 16'd80, 16'd0}, NN, NN, NN},
    '{NN, NN, NN, NN},
    '{'{16'd1000, 16'd90, 16'd35}, '{16'd650, 16'd140, 16'd0}, NN, NN},
    '{'{16'd650, 16'd90, 16'd35}, '{16'd1000, 16'd140, 16'd0}, NN, NN},
    '{'{16'd1600, 16'd40, 16'd0}, NN, NN, NN},
    '{'{16'd620, 16'd150, 16'd80}, '{16'd620, 16'd150, 16'd0}, NN, NN},
    '{'{16'd1150, 16'd60, 16'd60}, '{16'd1150, 16'd60, 16'd0}, NN, NN},
    '{'{16'd700, 16'd100, 16'd50}, '{16'd1000, 16'd100, 16'd50},
      '{16'd1400, 16'd180, 16'd0}, NN},
    '{'{16'd900, 16'd150, 16'd50}, '{16'd1200, 16'd150, 16'd50},
      '{16'd1500, 16'd150, 16'd0}, NN},
    '{'{16'd1250, 16'd65, 16'd35}, '{16'd1250, 16'd65, 16'd0}, NN, NN},
    '{'{16'd900, 16'd55, 16'd35}, '{16'd1250, 16'd55, 16'd35},
      '{16'd1650, 16'd90, 16'd0}, NN},
    '{'{16'd900, 16'd70, 16'd40}, '{16'd650, 16'd110, 16'd0}, NN, NN},
    '{'{16'd700, 16'd55, 16'd30}, '{16'd1050, 16'd80, 16'd0}, NN, NN},
    '{'{16'd500, 16'd70, 16'd35}, '{16'd850, 16'd95, 16'd0}, NN, NN},
    '{'{16'd1500, 16'd90, 16'd45}, '{16'd1000, 16'd110, 16'd45},
      '{16'd550, 16'd180, 16'd0}, NN},
    '{'{16'd900, 16'd80, 16'd40}, '{16'd1250, 16'd80, 16'd40},
      '{16'd1650, 16'd140, 16'd0}, NN},
    '{'{16'd1050, 16'd70, 16'd35}, '{16'd1450, 16'd110, 16'd0}, NN, NN},
    '{'{16'd1150, 16'd75, 16'd35}, '{16'd700, 16'd75, 16'd35},
      '{16'd420, 16'd140, 16'd0}, NN},
    '{'{16'd850, 16'd70, 16'd35}, '{16'd600, 16'd105, 16'd0}, NN, NN},
    '{'{16'd900, 16'd40, 16'd50}, '{16'd700, 16'd40, 16'd0}, NN, NN},
    '{'{16'd700, 16'd40, 16'd50}, '{16'd900, 16'd40, 16'd0}, NN, NN}
  };

endpackage

// ----- rtl/qtps_queue.sv -----
// ----------------------------------------------------------------------------
// qtps_queue
// Ring of pending jobs with head, tail and fill count.
// ----------------------------------------------------------------------------
module qtps_queue import qtps_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  q_ctrl_t   ctrl,
  output q_status_t status
);

  job_t              ring [QUEUE_DEPTH];
  logic [QIDX_W-1:0] head;
  logic [QIDX_W-1:0] tail;
  logic [QCNT_W-1:0] count;

  function automatic logic [QIDX_W-1:0] wrap_inc(input logic [QIDX_W-1:0] idx);
    logic [QIDX_W-1:0] res;
    if (idx == QIDX_W'(QUEUE_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = idx + 1'b1;
    end
    return res;
  endfunction

  assign status.empty    = (count == '0);
  assign status.full     = (count == QCNT_W'(QUEUE_DEPTH));
  assign status.head_job = ring[head];

  // entries carry no reset; a slot is only read after it was written
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      ring[tail] <= ctrl.push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.flush) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (ctrl.push) begin
        tail <= wrap_inc(tail);
      end
      if (ctrl.pop) begin
        head <= wrap_inc(head);
      end
      if (ctrl.push && !ctrl.pop) begin
        count <= count + 1'b1;
      end else if (ctrl.pop && !ctrl.push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/qtps_player.sv -----
// ----------------------------------------------------------------------------
// qtps_player
// Playback state: current job, note position and due time; emits tones.
// ----------------------------------------------------------------------------
module qtps_player import qtps_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              tick,
  input  logic              clear,
  input  logic [TIME_W-1:0] now,
  input  cfg_t              cfg,
  input  q_status_t         q_stat,
  output logic              pop,
  output tone_t             tone
);

  logic              playing;
  logic [POS_W-1:0]  note_position;
  logic [TIME_W-1:0] next_note_time;
  logic [CUE_W-1:0]  current_cue;
  logic [MASK_W-1:0] current_mask;

  logic              have_job;
  logic [CUE_W-1:0]  eff_cue;
  logic [MASK_W-1:0] eff_mask;
  logic [POS_W-1:0]  eff_pos;
  logic [TIME_W-1:0] eff_next;
  logic [TIME_W-1:0] diff;
  logic              due;
  logic              finished;
  logic              emit;
  logic              end_job;
  logic              restart;
  note_t             note;
  logic [MASK_W-1:0] allow_mask;
  logic [TIME_W-1:0] due_next;

  // an idle player takes the head job as if it started on this tick
  assign have_job = playing || !q_stat.empty;
  assign eff_cue  = playing ? current_cue    : q_stat.head_job.cue;
  assign eff_mask = playing ? current_mask   : q_stat.head_job.mask;
  assign eff_pos  = playing ? note_position  : '0;
  assign eff_next = playing ? next_note_time : now;

  assign diff     = now - eff_next;
  assign due      = !diff[TIME_W-1];
  assign finished = (eff_pos >= NOTE_TOTAL[eff_cue]) || (eff_pos >= POS_W'(MAX_NOTES));
  assign note     = TONE_ROM[eff_cue][eff_pos[NIDX_W-1:0]];

  assign emit    = tick && have_job && due && !finished;
  assign end_job = tick && playing && due && finished;
  assign restart = end_job && !q_stat.empty;
  assign pop     = (emit && !playing) || restart;

  assign allow_mask = MODULE_BITS | (cfg.speaker_audible ? SPEAKER_BIT : '0);
  assign due_next   = now + TIME_W'(note.dur) + TIME_W'(note.gap);

  always_comb begin
    tone = '0;
    if (emit) begin
      tone.valid = 1'b1;
      tone.mask  = eff_mask & ~cfg.muted_mask & allow_mask;
      tone.hz    = note.hz;
      tone.dur   = note.dur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      playing        <= 1'b0;
      note_position  <= '0;
      next_note_time <= '0;
      current_cue    <= '0;
      current_mask   <= '0;
    end else if (clear) begin
      playing        <= 1'b0;
      note_position  <= '0;
      next_note_time <= '0;
    end else if (emit) begin
      playing        <= 1'b1;
      current_cue    <= eff_cue;
      current_mask   <= eff_mask;
      note_position  <= eff_pos + 1'b1;
      next_note_time <= due_next;
    end else if (restart) begin
      // start the next job silently on this tick
      playing        <= 1'b1;
      current_cue    <= q_stat.head_job.cue;
      current_mask   <= q_stat.head_job.mask;
      note_position  <= '0;
      next_note_time <= now;
    end else if (end_job) begin
      playing <= 1'b0;
    end
  end

endmodule

// ----- rtl/queued_tone_pattern_sequencer.sv -----
// ----------------------------------------------------------------------------
// queued_tone_pattern_sequencer
// Queues cue requests and plays their note patterns on time ticks.
// ----------------------------------------------------------------------------
//  channel   | signals                                  | handshake
//  ----------+------------------------------------------+---------------------
//  request   | kind, cue, target_mask, now_ms           | start high, busy low
//  result    | accepted, tone_valid, tone_mask,         | done strobe, 1 cycle
//            | frequency_hz, duration_ms                |
//  config    | cfg_index, cfg_data                      | cfg_write high
//
//  One request per cycle; its result shows on done after the input and result registers.
//  The limit is the single pass through queue read, pattern ROM and due-time
//  add between the input register and the result register.
//  busy stays low; every accepted request gives exactly one result.
//  Synchronous reset clears queue, playback state and config to defaults.
//  Results cannot be stalled; done lasts exactly one cycle.
// ----------------------------------------------------------------------------
module queued_tone_pattern_sequencer import qtps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            kind,
  input  logic [CUE_W-1:0]      cue,
  input  logic [MASK_W-1:0]     target_mask,
  input  logic [TIME_W-1:0]     now_ms,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  done,
  output logic                  accepted,
  output logic                  tone_valid,
  output logic [MASK_W-1:0]     tone_mask,
  output logic [NOTE_W-1:0]     frequency_hz,
  output logic [NOTE_W-1:0]     duration_ms
);

  cfg_t              cfg;
  logic              in_valid;
  kind_t             kind_q;
  logic [CUE_W-1:0]  cue_q;
  logic [MASK_W-1:0] mask_q;
  logic [TIME_W-1:0] now_q;

  logic              is_req;
  logic              tick;
  logic              clear;
  logic [MASK_W-1:0] req_mask;
  logic              req_ok;
  logic              pop;
  q_ctrl_t           q_ctrl;
  q_status_t         q_stat;
  tone_t             tone;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.audio_enabled   <= 1'b1;
      cfg.muted_mask      <= '0;
      cfg.speaker_audible <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_AUDIO_ENABLED:   cfg.audio_enabled   <= cfg_data[0];
        CFG_MUTED_MASK:      cfg.muted_mask      <= cfg_data[MASK_W-1:0];
        CFG_SPEAKER_AUDIBLE: cfg.speaker_audible <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      kind_q <= kind_t'(kind);
      cue_q  <= cue;
      mask_q <= target_mask;
      now_q  <= now_ms;
    end
  end

  assign is_req = in_valid && (kind_q == KIND_REQUEST);
  assign tick   = in_valid && (kind_q == KIND_TICK);
  assign clear  = in_valid && (kind_q == KIND_CLEAR);

  assign req_mask = mask_q & ~cfg.muted_mask & ~(cfg.speaker_audible ? '0 : SPEAKER_BIT);
  assign req_ok   = is_req && (req_mask != '0) && cfg.audio_enabled &&
                    (NOTE_TOTAL[cue_q] != '0) && !q_stat.full;

  assign q_ctrl.push          = req_ok;
  assign q_ctrl.pop           = pop;
  assign q_ctrl.flush         = clear;
  assign q_ctrl.push_job.mask = req_mask;
  assign q_ctrl.push_job.cue  = cue_q;

  qtps_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (q_ctrl),
    .status (q_stat)
  );

  qtps_player u_player (
    .clk    (clk),
    .rst    (rst),
    .tick   (tick),
    .clear  (clear),
    .now    (now_q),
    .cfg    (cfg),
    .q_stat (q_stat),
    .pop    (pop),
    .tone   (tone)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      accepted     <= req_ok;
      tone_valid   <= tone.valid;
      tone_mask    <= tone.mask;
      frequency_hz <= tone.hz;
      duration_ms  <= tone.dur;
    end
  end

endmodule

// ----- rtl/qtps_checker.sv -----
// ----------------------------------------------------------------------------
// qtps_port_checks
// Port-level checks on request to result timing and result contents.
// ----------------------------------------------------------------------------
module qtps_port_checks (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic        accepted,
  input logic        tone_valid,
  input logic [15:0] tone_mask,
  input logic [15:0] frequency_hz,
  input logic [15:0] duration_ms
);

  // every accepted request yields a result on done
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("accepted request produced no result");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result without a matching request");

  a_tone_not_accepted: assert property (@(posedge clk) disable iff (rst)
    (done && tone_valid) |-> !accepted)
    else $error("tone and queue acceptance in the same result");

  a_silent_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !tone_valid) |-> (tone_mask == 16'd0 && frequency_hz == 16'd0 &&
                               duration_ms == 16'd0))
    else $error("tone fields nonzero without a tone");

endmodule

bind queued_tone_pattern_sequencer qtps_port_checks u_qtps_port_checks (.*);
